>>> rtl/kcl_pkg.sv
// Shared types and constants of the keypad code lock.
`default_nettype none

package kcl_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_PIN_CODE   = 2'd0;
    localparam logic [1:0] REG_PIN_LENGTH = 2'd1;
    localparam logic [1:0] REG_NEAR_THR   = 2'd2;
    localparam logic [1:0] REG_MAX_TRIES  = 2'd3;

    // Register values after reset.
    localparam logic [31:0] PIN_CODE_RST   = 32'd17185;
    localparam logic [3:0]  PIN_LENGTH_RST = 4'd4;
    localparam logic [8:0]  NEAR_THR_RST   = 9'd30;
    localparam logic [1:0]  MAX_TRIES_RST  = 2'd2;

    // Longest code that the pin_code register can describe.
    localparam logic [3:0] PIN_DIGITS_MAX = 4'd8;

    // Key codes with a meaning of their own.
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    // Indicator colors, bit 2 red, bit 1 green, bit 0 blue.
    localparam logic [2:0] LED_OFF    = 3'd0;
    localparam logic [2:0] LED_BLUE   = 3'd1;
    localparam logic [2:0] LED_GREEN  = 3'd2;
    localparam logic [2:0] LED_RED    = 3'd4;
    localparam logic [2:0] LED_YELLOW = 3'd6;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DETECTED = 3'd1,
        EV_GRANTED  = 3'd2,
        EV_WRONG    = 3'd3,
        EV_ALERT    = 3'd4,
        EV_INTRUDER = 3'd5,
        EV_RESET    = 3'd6
    } event_t;

    typedef struct packed {
        logic [31:0] pin_code;
        logic [3:0]  pin_length;
        logic [8:0]  near_threshold_cm;
        logic [1:0]  max_attempts;
    } cfg_t;

    typedef struct packed {
        logic [8:0] distance_cm;
        logic       key_valid;
        logic [3:0] key_code;
        logic       motion;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] led_rgb;
        logic       chirp;
        logic       siren;
        event_t     event_res;
    } result_t;

    // Update of the entry buffer requested by the mode machine.
    typedef struct packed {
        logic       clear;
        logic       append;
        logic [3:0] key;
    } entry_op_t;

endpackage

`default_nettype wire

>>> rtl/kcl_if.sv
// Request channels of the keypad code lock: input items and result items.
`default_nettype none

interface kcl_item_if;
    logic       valid;
    logic       ready;
    logic [8:0] distance_cm;
    logic       key_valid;
    logic [3:0] key_code;
    logic       motion;

    modport source (output valid, distance_cm, key_valid, key_code, motion, input ready);
    modport sink (input valid, distance_cm, key_valid, key_code, motion, output ready);
endinterface

interface kcl_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [2:0] led_rgb;
    logic       chirp;
    logic       siren;
    logic [2:0] event_res;

    modport source (output valid, mode, led_rgb, chirp, siren, event_res, input ready);
    modport sink (input valid, mode, led_rgb, chirp, siren, event_res, output ready);
endinterface

`default_nettype wire

>>> rtl/keypad_code_lock_fsm_unit.sv
// Keypad code lock: one request per polling pass of distance, key and motion.
//
// The item channel takes one polling pass per request: distance_cm, key_valid,
// key_code and motion. The res channel returns exactly one request per item:
// mode, led_rgb, chirp, siren and event_res, all as they stand after that pass.
// Both channels move a request on a rising edge with valid and ready high.
// An accepted item lands in the input register; on the edge where it moves
// on, the mode machine and the entry comparator run on it and load the result
// register, which then offers the result. One item per cycle is sustained
// while the receiver takes results: the input register advances whenever the
// result register is empty or being emptied in the same cycle.
// When the receiver holds ready low, the result stays put, the input register
// fills, and item.ready drops only once both are occupied.
// The configuration port writes pin_code, pin_length, near_threshold_cm and
// max_attempts (indexes 0 to 3) from cfg_data when cfg_we is high.
// Reset empties both registers, returns the lock to idle with the indicator
// and siren off and an empty entry, and loads the default code settings.
`default_nettype none

module keypad_code_lock_fsm_unit import kcl_pkg::*; #(
    parameter int MAX_DIGITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    kcl_item_if.sink         item,
    kcl_res_if.source        res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    item_t     in_item_reg;
    logic      out_valid_reg;
    logic      step;
    logic      match;
    entry_op_t entry_op;
    result_t   result;

    assign step       = in_valid_reg && (!out_valid_reg || res.ready);
    assign item.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_code          <= PIN_CODE_RST;
            cfg_reg.pin_length        <= PIN_LENGTH_RST;
            cfg_reg.near_threshold_cm <= NEAR_THR_RST;
            cfg_reg.max_attempts      <= MAX_TRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIN_CODE:   cfg_reg.pin_code          <= cfg_data;
                REG_PIN_LENGTH: cfg_reg.pin_length        <= cfg_data[3:0];
                REG_NEAR_THR:   cfg_reg.near_threshold_cm <= cfg_data[8:0];
                REG_MAX_TRIES:  cfg_reg.max_attempts      <= cfg_data[1:0];
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.distance_cm <= item.distance_cm;
            in_item_reg.key_valid   <= item.key_valid;
            in_item_reg.key_code    <= item.key_code;
            in_item_reg.motion      <= item.motion;
        end
    end

    kcl_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .op         (entry_op),
        .pin_code   (cfg_reg.pin_code),
        .pin_length (cfg_reg.pin_length),
        .match      (match)
    );

    kcl_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .item              (in_item_reg),
        .near_threshold_cm (cfg_reg.near_threshold_cm),
        .max_attempts      (cfg_reg.max_attempts),
        .match             (match),
        .entry_op          (entry_op),
        .result            (result)
    );

    assign res.valid     = out_valid_reg;
    assign res.mode      = result.mode;
    assign res.led_rgb   = result.led_rgb;
    assign res.chirp     = result.chirp;
    assign res.siren     = result.siren;
    assign res.event_res = result.event_res;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("input stalled while the result register is empty");

    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed request did not reach the result register");

endmodule

`default_nettype wire

>>> rtl/kcl_entry.sv
// Entry buffer of typed digits with its overflow flag and the code comparator.
`default_nettype none

module kcl_entry import kcl_pkg::*; #(
    parameter int MAX_DIGITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire entry_op_t   op,
    input  wire logic [31:0] pin_code,
    input  wire logic [3:0]  pin_length,
    output logic             match
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int NCMP  = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;

    logic [3:0]       digits_reg [MAX_DIGITS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             room;
    logic [NCMP-1:0]  digit_ok;
    logic             length_ok;

    assign room = count_reg < CNT_W'(MAX_DIGITS);

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (step && op.clear)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (step && op.append)
        begin
            if (room)
                count_next = CNT_W'(count_reg + 1'b1);
            else
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // Digit storage needs no reset: only digits below the fill count matter.
    always_ff @(posedge clk)
    begin
        if (step && !op.clear && op.append && room)
            digits_reg[count_reg[IDX_W-1:0]] <= op.key;
    end

    // A position past the code length always agrees.
    for (genvar gi = 0; gi < NCMP; gi++)
    begin : g_cmp
        assign digit_ok[gi] = (4'(gi) >= pin_length) ||
                              (digits_reg[gi] == pin_code[4*gi +: 4]);
    end

    assign length_ok = (pin_length != 4'd0) && (pin_length <= PIN_DIGITS_MAX) &&
                       (CMP_W'(count_reg) == CMP_W'(pin_length));
    assign match = !overflow_reg && length_ok && (&digit_ok);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("entry fill count ran past the buffer depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (step && op.clear) |=> (count_reg == '0 && !overflow_reg))
        else $error("entry not empty after a clear");

endmodule

`default_nettype wire

>>> rtl/kcl_ctrl.sv
// Mode machine of the lock with its indicator, siren and result registers.
`default_nettype none

module kcl_ctrl import kcl_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire item_t      item,
    input  wire logic [8:0] near_threshold_cm,
    input  wire logic [1:0] max_attempts,
    input  wire logic       match,
    output entry_op_t       entry_op,
    output result_t         result
);

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_AUTH    = 3'd1,
        MODE_GRANTED = 3'd2,
        MODE_ALERT   = 3'd3,
        MODE_ALARM   = 3'd4
    } mode_t;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [1:0] wrong_reg;
    logic [1:0] wrong_next;
    logic [1:0] wrong_inc;
    logic [2:0] led_reg;
    logic [2:0] led_next;
    logic       siren_reg;
    logic       siren_next;
    logic       chirp_reg;
    logic       chirp_next;
    event_t     event_reg;
    event_t     event_next;
    logic       is_hash;
    logic       is_star;

    assign is_hash   = item.key_valid && (item.key_code == KEY_HASH);
    assign is_star   = item.key_valid && (item.key_code == KEY_STAR);
    assign wrong_inc = (wrong_reg == 2'd3) ? wrong_reg : 2'(wrong_reg + 1'b1);

    always_comb
    begin
        mode_next       = mode_reg;
        wrong_next      = wrong_reg;
        led_next        = led_reg;
        siren_next      = siren_reg;
        chirp_next      = 1'b0;
        event_next      = EV_NONE;
        entry_op.clear  = 1'b0;
        entry_op.append = 1'b0;
        entry_op.key    = item.key_code;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (item.distance_cm <= near_threshold_cm)
                begin
                    led_next       = LED_BLUE;
                    mode_next      = MODE_AUTH;
                    wrong_next     = 2'd0;
                    entry_op.clear = 1'b1;
                    event_next     = EV_DETECTED;
                end
            end
            MODE_AUTH:
            begin
                if (is_hash)
                begin
                    chirp_next = 1'b1;
                    if (match)
                    begin
                        led_next   = LED_GREEN;
                        mode_next  = MODE_GRANTED;
                        event_next = EV_GRANTED;
                    end
                    else
                    begin
                        led_next       = LED_RED;
                        wrong_next     = wrong_inc;
                        entry_op.clear = 1'b1;
                        event_next     = EV_WRONG;
                        if (wrong_inc >= max_attempts)
                            mode_next = MODE_ALERT;
                    end
                end
                else if (is_star)
                    entry_op.clear = 1'b1;
                else if (item.key_valid)
                    entry_op.append = 1'b1;
            end
            MODE_GRANTED:
            begin
                mode_next = MODE_IDLE;
                led_next  = LED_OFF;
            end
            MODE_ALERT:
            begin
                chirp_next = 1'b1;
                event_next = EV_ALERT;
                if (item.motion)
                    mode_next = MODE_ALARM;
            end
            default:
            begin
                // Alarm: only the right code followed by hash leaves it.
                led_next   = LED_YELLOW;
                siren_next = 1'b1;
                event_next = EV_INTRUDER;
                if (is_hash)
                begin
                    entry_op.clear = 1'b1;
                    if (match)
                    begin
                        siren_next = 1'b0;
                        led_next   = LED_GREEN;
                        mode_next  = MODE_IDLE;
                        event_next = EV_RESET;
                    end
                end
                else if (item.key_valid)
                    entry_op.append = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            wrong_reg <= 2'd0;
            led_reg   <= LED_OFF;
            siren_reg <= 1'b0;
            chirp_reg <= 1'b0;
            event_reg <= EV_NONE;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            wrong_reg <= wrong_next;
            led_reg   <= led_next;
            siren_reg <= siren_next;
            chirp_reg <= chirp_next;
            event_reg <= event_next;
        end
    end

    assign result.mode      = mode_reg;
    assign result.led_rgb   = led_reg;
    assign result.chirp     = chirp_reg;
    assign result.siren     = siren_reg;
    assign result.event_res = event_reg;

    a_siren_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        siren_reg |-> (mode_reg == MODE_ALARM))
        else $error("siren sounding outside alarm mode");

endmodule

`default_nettype wire
